### rtl/sequenced_update_gap_tracker_macros.svh
// assertion helpers used by sugt_ctrl
`ifndef SEQUENCED_UPDATE_GAP_TRACKER_MACROS_SVH
`define SEQUENCED_UPDATE_GAP_TRACKER_MACROS_SVH

// same-cycle implication
`define SUGT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sugt assertion failed");

// next-cycle implication
`define SUGT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sugt assertion failed");

`endif

### rtl/sugt_pkg.sv
`timescale 1ns / 1ps
package sugt_pkg;

  localparam int OP_W       = 3;
  localparam int SEQ_W      = 63;
  localparam int ID_W       = 32;
  localparam int VAL_W      = 64;
  localparam int TIME_W     = 48;
  localparam int TO_W       = 47;
  localparam int LAST_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 47;

  localparam logic [OP_W-1:0] OP_MC_HDR   = 3'd0;
  localparam logic [OP_W-1:0] OP_MC_ENTRY = 3'd1;
  localparam logic [OP_W-1:0] OP_TCP_REPLY = 3'd2;
  localparam logic [OP_W-1:0] OP_TCP_HB   = 3'd3;
  localparam logic [OP_W-1:0] OP_TIME_CHK = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

  localparam logic [TO_W-1:0]   INIT_SILENCE_USEC = TO_W'(10 * 1000000);
  localparam logic [LAST_W-1:0] NONE_SEQ          = '1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SEQ_W-1:0]  sequence_number;
    logic              heartbeat_flag;
    logic [ID_W-1:0]   record_id;
    logic [VAL_W-1:0]  record_value;
    logic [TIME_W-1:0] now_usec;
  } item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ID_W-1:0]   write_id;
    logic [VAL_W-1:0]  write_value;
    logic [TIME_W-1:0] write_time;
    logic              gap_valid;
    logic [SEQ_W-1:0]  gap_low;
    logic [SEQ_W-1:0]  gap_high;
    logic              mcast_dead;
    logic              tcp_dead;
    logic              id_error;
  } result_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } sugt_cmd_t;

  typedef struct packed {
    logic clear_last;
  } sugt_stat_t;

endpackage

### rtl/sugt_intf.sv
`timescale 1ns / 1ps
interface sugt_item_if import sugt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SEQ_W-1:0]  sequence_number;
  logic              heartbeat_flag;
  logic [ID_W-1:0]   record_id;
  logic [VAL_W-1:0]  record_value;
  logic [TIME_W-1:0] now_usec;

  modport source (output valid, operation, sequence_number, heartbeat_flag,
                  record_id, record_value, now_usec, input ready);
  modport sink (input valid, operation, sequence_number, heartbeat_flag,
                record_id, record_value, now_usec, output ready);
endinterface

interface sugt_result_if import sugt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic [ID_W-1:0]   write_id;
  logic [VAL_W-1:0]  write_value;
  logic [TIME_W-1:0] write_time;
  logic              gap_valid;
  logic [SEQ_W-1:0]  gap_low;
  logic [SEQ_W-1:0]  gap_high;
  logic              mcast_dead;
  logic              tcp_dead;
  logic              id_error;

  modport source (output valid, write_valid, write_id, write_value, write_time,
                  gap_valid, gap_low, gap_high, mcast_dead, tcp_dead, id_error,
                  input ready);
  modport sink (input valid, write_valid, write_id, write_value, write_time,
                gap_valid, gap_low, gap_high, mcast_dead, tcp_dead, id_error,
                output ready);
endinterface

interface sugt_cfg_if import sugt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/sequenced_update_gap_tracker.sv
`timescale 1ns / 1ps
// receiver-side sequence tracker for a record-update feed
// item_in: one event word per handshake (multicast header, multicast entry,
//   reply entry, reply heartbeat or time check)
// result_out: exactly one result word per accepted event; gap requests,
//   record writes, silence verdicts and id errors share the word
// cfg: register writes (index 0 base id, index 1 silence timeout), taken
//   at any time with ready held high; write only while the block is idle
// flow: an accepted event and its memory read are registered; the exec
//   state then registers its result word; the next event waits for that
//   pass, set by the registered per-record memory read and its write-back
// reset: synchronous; afterwards a clearing pass writes every entry of the
//   sequence memory, during which item_in.ready is low
// stalls: a result word waits in the output register while result_out.ready
//   is low; the next event is taken in the cycle that word is accepted
module sequenced_update_gap_tracker import sugt_pkg::*; #(
  parameter int RECORD_COUNT = 1024,
  parameter int VALUE_BITS   = 64
) (
  input  logic          clk,
  input  logic          rst,
  sugt_item_if.sink     item_in,
  sugt_result_if.source result_out,
  sugt_cfg_if.sink      cfg
);

  sugt_cmd_t  cmd;
  sugt_stat_t stat;
  item_t      item;
  result_t    res;

  assign item.operation       = item_in.operation;
  assign item.sequence_number = item_in.sequence_number;
  assign item.heartbeat_flag  = item_in.heartbeat_flag;
  assign item.record_id       = item_in.record_id;
  assign item.record_value    = item_in.record_value;
  assign item.now_usec        = item_in.now_usec;

  assign cfg.ready = 1'b1;

  sugt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sugt_dpath #(
    .RECORD_COUNT (RECORD_COUNT),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res       (res)
  );

  assign result_out.write_valid = res.write_valid;
  assign result_out.write_id    = res.write_id;
  assign result_out.write_value = res.write_value;
  assign result_out.write_time  = res.write_time;
  assign result_out.gap_valid   = res.gap_valid;
  assign result_out.gap_low     = res.gap_low;
  assign result_out.gap_high    = res.gap_high;
  assign result_out.mcast_dead  = res.mcast_dead;
  assign result_out.tcp_dead    = res.tcp_dead;
  assign result_out.id_error    = res.id_error;

endmodule

### rtl/sugt_ctrl.sv
`timescale 1ns / 1ps
`include "sequenced_update_gap_tracker_macros.svh"
module sugt_ctrl import sugt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output sugt_cmd_t  cmd,
  input  sugt_stat_t stat
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.accept = accept;
  assign cmd.exec   = (state == ST_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (stat.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  `SUGT_ASSERT_NEXT(a_accept_to_exec, clk, rst, accept, state == ST_EXEC)
  `SUGT_ASSERT_NOW(a_exec_slot_free, clk, rst, state == ST_EXEC, !out_valid)
  `SUGT_ASSERT_NEXT(a_exec_gives_word, clk, rst, state == ST_EXEC, out_valid)
  `SUGT_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid)

endmodule

### rtl/sugt_dpath.sv
`timescale 1ns / 1ps
module sugt_dpath import sugt_pkg::*; #(
  parameter int RECORD_COUNT = 1024,
  parameter int VALUE_BITS   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sugt_cmd_t             cmd,
  output sugt_stat_t            stat,
  input  item_t                 item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               res
);

  localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;

  logic [ID_W-1:0]   base_id;
  logic [TO_W-1:0]   timeout;

  logic [SEQ_W-1:0]  exp_seq, exp_seq_next;
  logic [SEQ_W-1:0]  pkt_seq, pkt_seq_next;
  logic              pkt_acc, pkt_acc_next;
  logic [TIME_W-1:0] mc_time, mc_time_next;
  logic [TIME_W-1:0] tcp_time, tcp_time_next;

  logic [LAST_W-1:0] rec_seq [RECORD_COUNT];
  logic [LAST_W-1:0] rd_seq;
  logic [IDX_W-1:0]  clr_idx;

  logic [OP_W-1:0]       op_q;
  logic [SEQ_W-1:0]      seq_q;
  logic                  hb_q;
  logic [ID_W-1:0]       id_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [TIME_W-1:0]     now_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  hit_q;

  logic [ID_W-1:0]   offs;
  logic [TIME_W-1:0] mc_el, tcp_el;
  logic [TIME_W-1:0] mc_limit;
  logic              upd;
  logic [LAST_W-1:0] upd_seq;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [LAST_W-1:0] mem_wd;
  result_t           res_next;

  assign offs            = item.record_id - base_id;
  assign stat.clear_last = (clr_idx == IDX_W'(RECORD_COUNT - 1));

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= '0;
      timeout <= INIT_SILENCE_USEC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ID: base_id <= cfg_data[ID_W-1:0];
        CFG_TIMEOUT: timeout <= cfg_data[TO_W-1:0];
        default:     ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= item.operation;
      seq_q <= item.sequence_number;
      hb_q  <= item.heartbeat_flag;
      id_q  <= item.record_id;
      val_q <= item.record_value[VALUE_BITS-1:0];
      now_q <= item.now_usec;
      idx_q <= offs[IDX_W-1:0];
      hit_q <= (offs < ID_W'(RECORD_COUNT));
    end
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear && !stat.clear_last) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign mem_we = cmd.clear || (cmd.exec && upd);
  assign mem_wa = cmd.clear ? clr_idx : idx_q;
  assign mem_wd = cmd.clear ? NONE_SEQ : upd_seq;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_seq[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_seq <= rec_seq[offs[IDX_W-1:0]];
    end
  end

  assign mc_el    = now_q - mc_time;
  assign tcp_el   = now_q - tcp_time;
  assign mc_limit = ((exp_seq == '0) && (timeout < INIT_SILENCE_USEC)) ?
                    TIME_W'(INIT_SILENCE_USEC) : TIME_W'(timeout);

  always_comb begin
    res_next      = '0;
    exp_seq_next  = exp_seq;
    pkt_seq_next  = pkt_seq;
    pkt_acc_next  = pkt_acc;
    mc_time_next  = mc_time;
    tcp_time_next = tcp_time;
    upd           = 1'b0;
    upd_seq       = rd_seq;
    case (op_q)
      OP_MC_HDR: begin
        mc_time_next = now_q;
        if (!hb_q && (seq_q < exp_seq)) begin
          pkt_acc_next = 1'b0;
        end else begin
          if (seq_q > exp_seq) begin
            res_next.gap_valid = 1'b1;
            res_next.gap_low   = exp_seq;
            res_next.gap_high  = seq_q;
            exp_seq_next       = seq_q;
          end
          if (hb_q) begin
            pkt_acc_next = 1'b0;
          end else begin
            pkt_acc_next = 1'b1;
            pkt_seq_next = seq_q;
            exp_seq_next = seq_q + 1'b1;
          end
        end
      end
      OP_MC_ENTRY: begin
        if (pkt_acc) begin
          if (!hit_q) begin
            res_next.id_error = 1'b1;
          end else begin
            res_next.write_valid = 1'b1;
            res_next.write_id    = id_q;
            res_next.write_value = VAL_W'(val_q);
            res_next.write_time  = now_q;
            upd                  = 1'b1;
            upd_seq              = LAST_W'(pkt_seq);
          end
        end
      end
      OP_TCP_REPLY: begin
        tcp_time_next = now_q;
        if (!hit_q) begin
          res_next.id_error = 1'b1;
        end else if ((rd_seq == NONE_SEQ) || (LAST_W'(seq_q) > rd_seq)) begin
          res_next.write_valid = 1'b1;
          res_next.write_id    = id_q;
          res_next.write_value = VAL_W'(val_q);
          res_next.write_time  = now_q;
          upd                  = 1'b1;
          upd_seq              = LAST_W'(seq_q);
        end
      end
      OP_TCP_HB: begin
        tcp_time_next = now_q;
      end
      OP_TIME_CHK: begin
        res_next.mcast_dead = (mc_el >= mc_limit);
        res_next.tcp_dead   = (tcp_el >= TIME_W'(timeout));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_seq  <= '0;
      pkt_seq  <= '0;
      pkt_acc  <= 1'b0;
      mc_time  <= '0;
      tcp_time <= '0;
    end else if (cmd.exec) begin
      exp_seq  <= exp_seq_next;
      pkt_seq  <= pkt_seq_next;
      pkt_acc  <= pkt_acc_next;
      mc_time  <= mc_time_next;
      tcp_time <= tcp_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res <= res_next;
    end
  end

endmodule
